>>> sv/kpr_pkg.sv
package kpr_pkg;

	// Field and register widths
	localparam int KW  = 32;
	localparam int CW  = 64;
	localparam int IXW = 3;
	localparam int RSW = 25;

	// Block-scale input width and normalized width
	localparam int BW       = 51;
	localparam int NW       = 31;
	localparam int NORM_BIT = NW - 2;
	localparam int LDW      = $clog2(BW);

	// Square root and divider widths
	localparam int SQW       = 63;
	localparam int LW        = 31;
	localparam int SQ_STAGES = (SQW + 1) / 4;
	localparam int DNW       = 48;
	localparam int QW        = 17;
	localparam int DV_STAGES = (QW + 1) / 2;

	localparam logic [KW-1:0] ONE_Q16 = 32'h0001_0000;

	typedef enum logic [IXW-1:0] {
		REG_SRC_ROT_XY = 3'd0,
		REG_SRC_ROT_ZW = 3'd1,
		REG_DST_ROT_XY = 3'd2,
		REG_DST_ROT_ZW = 3'd3,
		REG_SRC_POS_XY = 3'd4,
		REG_DST_POS_XY = 3'd5,
		REG_POS_Z_PAIR = 3'd6,
		REG_ROOT_SCALE = 3'd7
	} reg_idx_t;

	typedef logic signed [BW-1:0] wide_t;
	typedef logic signed [NW-1:0] norm_t;

	// Item context carried down the pipe; index 0 is w, then x, y, z
	typedef struct packed {
		logic                 op;
		logic                 ident;
		logic [3:0][KW-1:0]   k;
		logic [2:0][KW-1:0]   t;
		logic [3:0][NW-1:0]   b;
	} item_t;

endpackage

>>> sv/kpr_bscale.sv
module kpr_bscale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  kpr_pkg::wide_t   vec [4],
	input  kpr_pkg::item_t   item,
	output logic             norm_valid,
	output kpr_pkg::norm_t   norm [4],
	output logic             zero,
	output kpr_pkg::item_t   norm_item
);

	logic [kpr_pkg::BW-1:0]  mag [4];
	logic [kpr_pkg::BW-1:0]  mag_or;
	logic [kpr_pkg::LDW-1:0] lead;

	logic                    v_s1, v_s2, v_s3;
	kpr_pkg::wide_t          vec_s1 [4];
	kpr_pkg::wide_t          vec_s2 [4];
	logic [kpr_pkg::BW-1:0]  or_s1;
	logic                    right_s2, zero_s2, zero_s3;
	logic [kpr_pkg::LDW-1:0] sh_s2;
	kpr_pkg::norm_t          norm_s3 [4];
	kpr_pkg::item_t          item_s1, item_s2, item_s3;

	// Leading one of the largest magnitude equals leading one of the OR
	always_comb begin
		mag_or = '0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = vec[i][kpr_pkg::BW-1] ? kpr_pkg::BW'(-vec[i]) : kpr_pkg::BW'(vec[i]);
			mag_or = mag_or | mag[i];
		end
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < kpr_pkg::BW; i++) begin
			if (or_s1[i]) lead = kpr_pkg::LDW'(i);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: magnitude OR; stage 2: shift amount; stage 3: apply shift
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1   <= vec;
			or_s1    <= mag_or;
			item_s1  <= item;
			vec_s2   <= vec_s1;
			item_s2  <= item_s1;
			zero_s2  <= (or_s1 == '0);
			right_s2 <= (int'(lead) > kpr_pkg::NORM_BIT);
			sh_s2    <= (int'(lead) > kpr_pkg::NORM_BIT) ?
				kpr_pkg::LDW'(int'(lead) - kpr_pkg::NORM_BIT) :
				kpr_pkg::LDW'(kpr_pkg::NORM_BIT - int'(lead));
			item_s3  <= item_s2;
			zero_s3  <= zero_s2;
			for (int i = 0; i < 4; i++) begin
				norm_s3[i] <= right_s2 ? kpr_pkg::NW'(vec_s2[i] >>> sh_s2) :
					kpr_pkg::NW'(vec_s2[i] <<< sh_s2);
			end
		end
	end

	assign norm_valid = v_s3;
	assign norm       = norm_s3;
	assign zero       = zero_s3;
	assign norm_item  = item_s3;

	a_zero_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && zero_s3 |-> (norm_s3[0] == '0) && (norm_s3[1] == '0) &&
			(norm_s3[2] == '0) && (norm_s3[3] == '0))
		else $error("zero block scale with nonzero output");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !zero_s2 && !right_s2 |-> sh_s2 <= kpr_pkg::LDW'(kpr_pkg::NORM_BIT))
		else $error("left shift beyond normalize target");

endmodule

>>> sv/kpr_sqrt.sv
module kpr_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid,
	input  logic [kpr_pkg::SQW-1:0] sum,
	input  kpr_pkg::item_t         item,
	output logic                   root_valid,
	output logic [kpr_pkg::LW-1:0] root,
	output kpr_pkg::item_t         root_item
);

	typedef struct packed {
		logic [kpr_pkg::SQW-1:0] rem;
		logic [kpr_pkg::SQW-1:0] res;
	} sq_t;

	// One digit of the bitwise square root
	function automatic sq_t sqrt_step(input sq_t s, input int e);
		logic [kpr_pkg::SQW-1:0] bitv;
		logic [kpr_pkg::SQW-1:0] trial;
		sq_t r;
		bitv  = kpr_pkg::SQW'(1) << e;
		trial = s.res + bitv;
		if (s.rem >= trial) begin
			r.rem = s.rem - trial;
			r.res = (s.res >> 1) + bitv;
		end else begin
			r.rem = s.rem;
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	sq_t            sq_s   [kpr_pkg::SQ_STAGES+1];
	logic           v_s    [kpr_pkg::SQ_STAGES+1];
	kpr_pkg::item_t item_s [kpr_pkg::SQ_STAGES+1];

	assign sq_s[0].rem = sum;
	assign sq_s[0].res = '0;
	assign v_s[0]      = valid;
	assign item_s[0]   = item;

	// Two result bits per stage
	for (genvar g = 0; g < kpr_pkg::SQ_STAGES; g++) begin : g_stage
		localparam int E1 = kpr_pkg::SQW - 1 - 4 * g;
		sq_t nxt;

		always_comb begin
			nxt = sqrt_step(sqrt_step(sq_s[g], E1), E1 - 2);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g+1]   <= nxt;
				item_s[g+1] <= item_s[g];
			end
		end
	end

	assign root_valid = v_s[kpr_pkg::SQ_STAGES];
	assign root       = sq_s[kpr_pkg::SQ_STAGES].res[kpr_pkg::LW-1:0];
	assign root_item  = item_s[kpr_pkg::SQ_STAGES];

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[kpr_pkg::SQ_STAGES] |->
			sq_s[kpr_pkg::SQ_STAGES].res[kpr_pkg::SQW-1:kpr_pkg::LW] == '0)
		else $error("square root exceeds length width");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[kpr_pkg::SQ_STAGES] |->
			sq_s[kpr_pkg::SQ_STAGES].rem <= (sq_s[kpr_pkg::SQ_STAGES].res << 1))
		else $error("square root remainder too large");

endmodule

>>> sv/keyframe_pose_retarget.sv
// Retargets one animation key per word, Q16.16 throughout.
// Input channel: in_valid / in_stall carry operation and in_x..in_w. A rotation
// key (operation 0) returns normalize(dst_bind * conj(src_bind) * key) as
// out_x..out_w (identity if a product is zero); a root translation key
// (operation 1) returns dst_pos + (key - src_pos) * root_scale with out_w zero.
// Output channel: out_valid / out_stall, one result word per input word, in order.
// Configuration: wr_en, wr_index, wr_data write the bind registers; write them
// only while no word is in flight.
// Pipeline: the two quaternion products with their block scales (10 stages),
// the square of the length (2 stages), the 16-stage square root at two bits
// per stage and the 9-stage divider at two quotient bits per stage (one in
// the last), then the output register.
// Throughput: one word per cycle while in_stall is low; every stage is a plain
// register that moves together with the others.
// When the receiver stalls, the output register holds and a skid register
// catches the one word still leaving the pipe; in_stall rises only once the
// skid register is full and the whole pipe holds.
// Reset clears all valid bits and returns the bind registers to identity
// rotations, zero positions and unit root scale.
module keyframe_pose_retarget (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic signed [31:0]      in_x,
	input  logic signed [31:0]      in_y,
	input  logic signed [31:0]      in_z,
	input  logic signed [31:0]      in_w,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic signed [31:0]      out_w,
	input  logic                    wr_en,
	input  logic [kpr_pkg::IXW-1:0] wr_index,
	input  logic [kpr_pkg::CW-1:0]  wr_data
);

	localparam int KW  = kpr_pkg::KW;
	localparam int P1W = 2 * KW + 1 - 16;
	localparam int P2W = kpr_pkg::NW + KW - 16;
	localparam int TOW = KW + 1;
	localparam int TPW = TOW + kpr_pkg::RSW + 1;
	localparam int TRW = TPW - 16;
	localparam int SSW = 2 * kpr_pkg::NW - 1;
	localparam int DV  = kpr_pkg::DV_STAGES;

	// Product terms negated in each quaternion component (bit n of row m)
	localparam logic [3:0] QNEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	typedef struct packed {
		logic [KW-1:0] x;
		logic [KW-1:0] y;
		logic [KW-1:0] z;
		logic [KW-1:0] w;
	} res_t;

	typedef struct packed {
		logic [kpr_pkg::DNW-1:0] rem;
		logic [kpr_pkg::QW-1:0]  q;
	} dv_t;

	function automatic logic [KW-1:0] sat32(input logic signed [TRW:0] v);
		if (v > (TRW+1)'(64'sd2147483647)) return 32'h7fff_ffff;
		if (v < -(TRW+1)'(64'sd2147483648)) return 32'h8000_0000;
		return v[KW-1:0];
	endfunction

	// One restoring division step for quotient bit i
	function automatic dv_t div_step(input dv_t s, input logic [kpr_pkg::LW-1:0] d,
		input int i);
		logic [kpr_pkg::DNW-1:0] sh;
		dv_t r;
		sh = kpr_pkg::DNW'(d) << i;
		r  = s;
		if (s.rem >= sh) begin
			r.rem = s.rem - sh;
			r.q   = s.q | (kpr_pkg::QW'(1) << i);
		end
		return r;
	endfunction

	// ---------------- configuration registers ----------------
	logic [kpr_pkg::CW-1:0]  src_rot_xy_q, src_rot_zw_q, dst_rot_xy_q, dst_rot_zw_q;
	logic [kpr_pkg::CW-1:0]  src_pos_xy_q, dst_pos_xy_q, pos_z_pair_q;
	logic [kpr_pkg::RSW-1:0] root_scale_q;

	// Write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rot_xy_q <= '0;
			src_rot_zw_q <= {kpr_pkg::ONE_Q16, 32'h0};
			dst_rot_xy_q <= '0;
			dst_rot_zw_q <= {kpr_pkg::ONE_Q16, 32'h0};
			src_pos_xy_q <= '0;
			dst_pos_xy_q <= '0;
			pos_z_pair_q <= '0;
			root_scale_q <= kpr_pkg::RSW'(kpr_pkg::ONE_Q16);
		end else if (wr_en) begin
			case (kpr_pkg::reg_idx_t'(wr_index))
				kpr_pkg::REG_SRC_ROT_XY: src_rot_xy_q <= wr_data;
				kpr_pkg::REG_SRC_ROT_ZW: src_rot_zw_q <= wr_data;
				kpr_pkg::REG_DST_ROT_XY: dst_rot_xy_q <= wr_data;
				kpr_pkg::REG_DST_ROT_ZW: dst_rot_zw_q <= wr_data;
				kpr_pkg::REG_SRC_POS_XY: src_pos_xy_q <= wr_data;
				kpr_pkg::REG_DST_POS_XY: dst_pos_xy_q <= wr_data;
				kpr_pkg::REG_POS_Z_PAIR: pos_z_pair_q <= wr_data;
				kpr_pkg::REG_ROOT_SCALE: root_scale_q <= wr_data[kpr_pkg::RSW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipe control ----------------
	logic en;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	// ---------------- stage 1: D * conj(S) terms, key offsets ----------------
	logic signed [KW-1:0]  dq [4];
	logic signed [KW:0]    cs [4];
	logic signed [2*KW:0]  pr1 [4][4];
	logic signed [KW-1:0]  sp [3];
	logic signed [KW-1:0]  dp [3];
	logic signed [KW-1:0]  kin [3];

	logic                  v_s1, v_s2;
	logic signed [P1W-1:0] p1_s1 [4][4];
	logic signed [TOW-1:0] off_s1 [3];
	kpr_pkg::item_t        item_s1, item_s2;

	always_comb begin
		dq[0] = $signed(dst_rot_zw_q[63:32]);
		dq[1] = $signed(dst_rot_xy_q[31:0]);
		dq[2] = $signed(dst_rot_xy_q[63:32]);
		dq[3] = $signed(dst_rot_zw_q[31:0]);
		cs[0] = (KW+1)'($signed(src_rot_zw_q[63:32]));
		cs[1] = -(KW+1)'($signed(src_rot_xy_q[31:0]));
		cs[2] = -(KW+1)'($signed(src_rot_xy_q[63:32]));
		cs[3] = -(KW+1)'($signed(src_rot_zw_q[31:0]));
		for (int m = 0; m < 4; m++) begin
			for (int n = 0; n < 4; n++) begin
				pr1[m][n] = (2*KW+1)'(dq[n]) * (2*KW+1)'(cs[m ^ n]);
			end
		end
		sp[0]  = $signed(src_pos_xy_q[31:0]);
		sp[1]  = $signed(src_pos_xy_q[63:32]);
		sp[2]  = $signed(pos_z_pair_q[31:0]);
		dp[0]  = $signed(dst_pos_xy_q[31:0]);
		dp[1]  = $signed(dst_pos_xy_q[63:32]);
		dp[2]  = $signed(pos_z_pair_q[63:32]);
		kin[0] = in_x;
		kin[1] = in_y;
		kin[2] = in_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				for (int n = 0; n < 4; n++) begin
					p1_s1[m][n] <= P1W'(pr1[m][n] >>> 16);
				end
			end
			for (int i = 0; i < 3; i++) begin
				off_s1[i] <= TOW'(kin[i]) - TOW'(sp[i]);
			end
			item_s1.op    <= operation;
			item_s1.ident <= 1'b0;
			item_s1.k     <= {in_z, in_y, in_x, in_w};
			item_s1.t     <= '0;
			item_s1.b     <= '0;
		end
	end

	// ---------------- stage 2: component sums, translation product ----------------
	kpr_pkg::wide_t        a_sum [4];
	kpr_pkg::wide_t        a_s2 [4];
	logic signed [TPW-1:0] tp_s2 [3];

	always_comb begin
		for (int m = 0; m < 4; m++) begin
			a_sum[m] = '0;
			for (int n = 0; n < 4; n++) begin
				if (QNEG[m][n]) a_sum[m] = a_sum[m] - kpr_pkg::BW'(p1_s1[m][n]);
				else            a_sum[m] = a_sum[m] + kpr_pkg::BW'(p1_s1[m][n]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_sum;
			item_s2 <= item_s1;
			for (int i = 0; i < 3; i++) begin
				tp_s2[i] <= TPW'(off_s1[i]) * $signed(TPW'({1'b0, root_scale_q}));
			end
		end
	end

	// Round the translation, add the target bind position, clamp
	logic signed [TRW-1:0] t_rnd [3];
	logic signed [TRW:0]   t_sum [3];
	kpr_pkg::item_t        item_a_in;

	always_comb begin
		item_a_in = item_s2;
		for (int i = 0; i < 3; i++) begin
			t_rnd[i]       = TRW'((tp_s2[i] + TPW'(32768)) >>> 16);
			t_sum[i]       = (TRW+1)'(t_rnd[i]) + (TRW+1)'(dp[i]);
			item_a_in.t[i] = sat32(t_sum[i]);
		end
	end

	// ---------------- block scale of D * conj(S) ----------------
	logic           va;
	kpr_pkg::norm_t na [4];
	logic           zero_a;
	kpr_pkg::item_t item_a;

	kpr_bscale u_scale_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (v_s2),
		.vec        (a_s2),
		.item       (item_a_in),
		.norm_valid (va),
		.norm       (na),
		.zero       (zero_a),
		.norm_item  (item_a)
	);

	// ---------------- stage 6/7: second product with the key ----------------
	logic signed [kpr_pkg::NW+KW-1:0] pr2 [4][4];
	logic signed [P2W-1:0]            p2_s6 [4][4];
	kpr_pkg::wide_t                   b_sum [4];
	kpr_pkg::wide_t                   b_s7 [4];
	logic                             v_s6, v_s7;
	kpr_pkg::item_t                   item_s6, item_s7;

	always_comb begin
		for (int m = 0; m < 4; m++) begin
			for (int n = 0; n < 4; n++) begin
				pr2[m][n] = (kpr_pkg::NW+KW)'(na[n]) *
					(kpr_pkg::NW+KW)'($signed(item_a.k[m ^ n]));
			end
		end
	end

	always_comb begin
		for (int m = 0; m < 4; m++) begin
			b_sum[m] = '0;
			for (int n = 0; n < 4; n++) begin
				if (QNEG[m][n]) b_sum[m] = b_sum[m] - kpr_pkg::BW'(p2_s6[m][n]);
				else            b_sum[m] = b_sum[m] + kpr_pkg::BW'(p2_s6[m][n]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= va;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				for (int n = 0; n < 4; n++) begin
					p2_s6[m][n] <= P2W'(pr2[m][n] >>> 16);
				end
			end
			item_s6       <= item_a;
			item_s6.ident <= zero_a;
			b_s7          <= b_sum;
			item_s7       <= item_s6;
		end
	end

	// ---------------- block scale of the rotated key ----------------
	logic           vb;
	kpr_pkg::norm_t nb [4];
	logic           zero_b;
	kpr_pkg::item_t item_b;

	kpr_bscale u_scale_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (v_s7),
		.vec        (b_s7),
		.item       (item_s7),
		.norm_valid (vb),
		.norm       (nb),
		.zero       (zero_b),
		.norm_item  (item_b)
	);

	// ---------------- stage 11/12: squared length ----------------
	logic signed [SSW:0]          sq_full [4];
	logic [SSW-1:0]               sq_s11 [4];
	logic [kpr_pkg::SQW-1:0]      sum_s12;
	logic                         v_s11, v_s12;
	kpr_pkg::item_t               item_s11, item_s12;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq_full[i] = (SSW+1)'(nb[i]) * (SSW+1)'(nb[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s11 <= vb;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s11[i] <= sq_full[i][SSW-1:0];
			end
			item_s11       <= item_b;
			item_s11.ident <= item_b.ident | zero_b;
			item_s11.b     <= {nb[3], nb[2], nb[1], nb[0]};
			sum_s12        <= kpr_pkg::SQW'(sq_s11[0]) + kpr_pkg::SQW'(sq_s11[1]) +
				kpr_pkg::SQW'(sq_s11[2]) + kpr_pkg::SQW'(sq_s11[3]);
			item_s12       <= item_s11;
		end
	end

	// ---------------- length ----------------
	logic                    vr;
	logic [kpr_pkg::LW-1:0]  len;
	kpr_pkg::item_t          item_r;

	kpr_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (v_s12),
		.sum        (sum_s12),
		.item       (item_s12),
		.root_valid (vr),
		.root       (len),
		.root_item  (item_r)
	);

	// ---------------- divider: |b| * 65536 / len, rounded ----------------
	dv_t                    dv_s   [DV+1][4];
	logic                   dv_v   [DV+1];
	logic [kpr_pkg::LW-1:0] dv_len [DV+1];
	kpr_pkg::item_t         dv_item[DV+1];
	logic [kpr_pkg::NW-1:0] bmag [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			bmag[l]       = item_r.b[l][kpr_pkg::NW-1] ?
				kpr_pkg::NW'(-$signed(item_r.b[l])) : item_r.b[l];
			dv_s[0][l].rem = (kpr_pkg::DNW'(bmag[l]) << 16) + kpr_pkg::DNW'(len >> 1);
			dv_s[0][l].q   = '0;
		end
	end

	assign dv_v[0]    = vr;
	assign dv_len[0]  = len;
	assign dv_item[0] = item_r;

	// Two quotient bits per stage, one in the last
	for (genvar g = 0; g < DV; g++) begin : g_div
		localparam int I1 = kpr_pkg::QW - 1 - 2 * g;
		dv_t nxt [4];

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				nxt[l] = div_step(dv_s[g][l], dv_len[g], I1);
			end
			if (I1 > 0) begin
				for (int l = 0; l < 4; l++) begin
					nxt[l] = div_step(nxt[l], dv_len[g], (I1 > 0) ? I1 - 1 : 0);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[g+1] <= 1'b0;
			end else if (en) begin
				dv_v[g+1] <= dv_v[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[g+1]    <= nxt;
				dv_len[g+1]  <= dv_len[g];
				dv_item[g+1] <= dv_item[g];
			end
		end
	end

	// ---------------- result select ----------------
	logic [KW-1:0] rot [4];
	res_t          res_d;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			rot[l] = KW'(dv_s[DV][l].q);
			if (dv_item[DV].b[l][kpr_pkg::NW-1]) rot[l] = -rot[l];
		end
		if (dv_item[DV].op) begin
			res_d = '{x: dv_item[DV].t[0], y: dv_item[DV].t[1], z: dv_item[DV].t[2], w: '0};
		end else if (dv_item[DV].ident) begin
			res_d = '{x: '0, y: '0, z: '0, w: kpr_pkg::ONE_Q16};
		end else begin
			res_d = '{x: rot[1], y: rot[2], z: rot[3], w: rot[0]};
		end
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (dv_v[DV]) begin
				if (!out_v_q || !out_stall) out_v_q  <= 1'b1;
				else                        skid_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end else if (!out_stall) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && dv_v[DV]) begin
			if (!out_v_q || !out_stall) out_q  <= res_d;
			else                        skid_q <= res_d;
		end else if (skid_v_q && !out_stall) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_x     = $signed(out_q.x);
	assign out_y     = $signed(out_q.y);
	assign out_z     = $signed(out_q.z);
	assign out_w     = $signed(out_q.w);

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word without output word");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid filled while output was free");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v[DV] && !dv_item[DV].op && !dv_item[DV].ident |->
			(dv_s[DV][0].q <= kpr_pkg::QW'(kpr_pkg::ONE_Q16)) &&
			(dv_s[DV][1].q <= kpr_pkg::QW'(kpr_pkg::ONE_Q16)) &&
			(dv_s[DV][2].q <= kpr_pkg::QW'(kpr_pkg::ONE_Q16)) &&
			(dv_s[DV][3].q <= kpr_pkg::QW'(kpr_pkg::ONE_Q16)))
		else $error("normalized component above one");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

import kpr_pkg::*;

// Expected output word of the retarget block
typedef struct {
	logic [31:0] x, y, z, w;
} pose_word_t;

class retarget_scoreboard;
	logic [63:0] bind_reg [8];
	pose_word_t  pending [$];
	int          fails;
	int          rot_keys, pos_keys, ident_keys, checked;

	function new();
		fails = 0; rot_keys = 0; pos_keys = 0; ident_keys = 0; checked = 0;
		bind_reg[REG_SRC_ROT_XY] = 64'd0;
		bind_reg[REG_SRC_ROT_ZW] = {ONE_Q16, 32'd0};
		bind_reg[REG_DST_ROT_XY] = 64'd0;
		bind_reg[REG_DST_ROT_ZW] = {ONE_Q16, 32'd0};
		bind_reg[REG_SRC_POS_XY] = 64'd0;
		bind_reg[REG_DST_POS_XY] = 64'd0;
		bind_reg[REG_POS_Z_PAIR] = 64'd0;
		bind_reg[REG_ROOT_SCALE] = 64'd65536;
	endfunction

	function void set_reg(reg_idx_t idx, logic [63:0] val);
		if (idx == REG_ROOT_SCALE)
			bind_reg[idx] = {39'd0, val[24:0]};
		else
			bind_reg[idx] = val;
	endfunction

	function longint lo(logic [63:0] v);
		return longint'(signed'(v[31:0]));
	endfunction

	function longint hi(logic [63:0] v);
		return longint'(signed'(v[63:32]));
	endfunction

	function logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// Hamilton product, index 0 is w; each term floored after the shift
	function void qprod(input longint a[4], input longint b[4], output longint r[4]);
		r[0] = (a[0]*b[0] >>> 16) - (a[1]*b[1] >>> 16) - (a[2]*b[2] >>> 16) - (a[3]*b[3] >>> 16);
		r[1] = (a[0]*b[1] >>> 16) + (a[1]*b[0] >>> 16) + (a[2]*b[3] >>> 16) - (a[3]*b[2] >>> 16);
		r[2] = (a[0]*b[2] >>> 16) - (a[1]*b[3] >>> 16) + (a[2]*b[0] >>> 16) + (a[3]*b[1] >>> 16);
		r[3] = (a[0]*b[3] >>> 16) + (a[1]*b[2] >>> 16) - (a[2]*b[1] >>> 16) + (a[3]*b[0] >>> 16);
	endfunction

	// Shared power-of-two rescale into [2^29, 2^30); zero vector reports false
	function bit rescale(ref longint a[4]);
		longint unsigned m, mag;
		int sh;
		m = 0;
		sh = 0;
		for (int i = 0; i < 4; i++) begin
			mag = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
			if (mag > m) m = mag;
		end
		if (m == 0) return 0;
		if (m >= (64'd1 << 30)) begin
			while ((m >> sh) >= (64'd1 << 30)) sh++;
			for (int i = 0; i < 4; i++) a[i] = a[i] >>> sh;
		end else begin
			while ((m << sh) < (64'd1 << 29)) sh++;
			for (int i = 0; i < 4; i++) a[i] = a[i] <<< sh;
		end
		return 1;
	endfunction

	function longint unsigned root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// Note one accepted key and queue its retargeted word
	function void note_key(logic op, logic [31:0] kx, ky, kz, kw);
		longint key[4], cs[4], d[4], a[4], b[4];
		longint unsigned sum, len, mag;
		longint qv, off, prod;
		longint sp[3], dp[3];
		pose_word_t e;
		logic [31:0] o[4];
		key[0] = longint'(signed'(kw));
		key[1] = longint'(signed'(kx));
		key[2] = longint'(signed'(ky));
		key[3] = longint'(signed'(kz));
		if (op == 1'b0) begin
			rot_keys++;
			cs[0] = hi(bind_reg[REG_SRC_ROT_ZW]);
			cs[1] = -lo(bind_reg[REG_SRC_ROT_XY]);
			cs[2] = -hi(bind_reg[REG_SRC_ROT_XY]);
			cs[3] = -lo(bind_reg[REG_SRC_ROT_ZW]);
			d[0] = hi(bind_reg[REG_DST_ROT_ZW]);
			d[1] = lo(bind_reg[REG_DST_ROT_XY]);
			d[2] = hi(bind_reg[REG_DST_ROT_XY]);
			d[3] = lo(bind_reg[REG_DST_ROT_ZW]);
			qprod(d, cs, a);
			e = '{32'd0, 32'd0, 32'd0, ONE_Q16};
			if (rescale(a)) begin
				qprod(a, key, b);
				if (rescale(b)) begin
					sum = 0;
					for (int i = 0; i < 4; i++) sum += longint'(b[i] * b[i]);
					len = root64(sum);
					for (int i = 0; i < 4; i++) begin
						mag = (b[i] < 0) ? longint'(-b[i]) : longint'(b[i]);
						qv = longint'((mag * 65536 + len / 2) / len);
						if (b[i] < 0) qv = -qv;
						o[i] = clamp32(qv);
					end
					e = '{o[1], o[2], o[3], o[0]};
				end else
					ident_keys++;
			end else
				ident_keys++;
		end else begin
			pos_keys++;
			sp[0] = lo(bind_reg[REG_SRC_POS_XY]);
			sp[1] = hi(bind_reg[REG_SRC_POS_XY]);
			sp[2] = lo(bind_reg[REG_POS_Z_PAIR]);
			dp[0] = lo(bind_reg[REG_DST_POS_XY]);
			dp[1] = hi(bind_reg[REG_DST_POS_XY]);
			dp[2] = hi(bind_reg[REG_POS_Z_PAIR]);
			for (int i = 0; i < 3; i++) begin
				off = key[i + 1] - sp[i];
				prod = off * longint'(bind_reg[REG_ROOT_SCALE]);
				o[i] = clamp32(dp[i] + ((prod + 32768) >>> 16));
			end
			e = '{o[0], o[1], o[2], 32'd0};
		end
		pending.push_back(e);
	endfunction

	// Compare one output word with the oldest expectation
	function void check_word(logic [31:0] ax, ay, az, aw);
		pose_word_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected output word x=%h y=%h z=%h w=%h", $time, ax, ay, az, aw);
			fails++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (ax !== e.x) begin
			$display("%0t: out_x expected %h actual %h", $time, e.x, ax);
			fails++;
		end
		if (ay !== e.y) begin
			$display("%0t: out_y expected %h actual %h", $time, e.y, ay);
			fails++;
		end
		if (az !== e.z) begin
			$display("%0t: out_z expected %h actual %h", $time, e.z, az);
			fails++;
		end
		if (aw !== e.w) begin
			$display("%0t: out_w expected %h actual %h", $time, e.w, aw);
			fails++;
		end
	endfunction
endclass

module tb;
	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT  = 4000;

	logic        clk, arst_n;
	logic        in_valid, in_stall, operation;
	logic [31:0] in_x, in_y, in_z, in_w;
	logic        out_valid, out_stall;
	logic [31:0] out_x, out_y, out_z, out_w;
	logic        wr_en;
	logic [IXW-1:0] wr_index;
	logic [CW-1:0]  wr_data;

	retarget_scoreboard sb;
	bit idle_on;
	int quiet_cycles;
	int stall_left;

	keyframe_pose_retarget uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Track accepted words on both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_key(operation, in_x, in_y, in_z, in_w);
			if (out_valid && !out_stall)
				sb.check_word(out_x, out_y, out_z, out_w);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver stall in random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 12);
		out_stall <= idle_on && (stall_left > 0);
	end

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom_range(0, 131071) - 65536;
			4: return $urandom >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_key(logic op, logic [31:0] kx, ky, kz, kw);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		in_x <= kx; in_y <= ky; in_z <= kz; in_w <= kw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drain the pipe, then load all bind registers back to back
	task automatic load_binds(logic [63:0] vals [8]);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data  <= vals[i];
			sb.set_reg(reg_idx_t'(i), vals[i]);
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic random_keys(int n);
		repeat (n)
			send_key($urandom_range(0, 2) != 0, rand_comp(), rand_comp(),
				rand_comp(), rand_comp());
	endtask

	function automatic logic [31:0] rand_rot();
		if ($urandom_range(0, 3) == 0) return rand_comp();
		return $urandom_range(0, 131072) - 65536;
	endfunction

	initial begin
		logic [63:0] cfg [8];
		sb = new();
		idle_on = 1'b1;
		quiet_cycles = 0;
		stall_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; operation = 1'b0;
		in_x = 0; in_y = 0; in_z = 0; in_w = 0;
		out_stall = 1'b0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words on reset binds: identity, zero key, extremes
		send_key(1'b0, 32'd0, 32'd0, 32'd0, ONE_Q16);
		send_key(1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_key(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_key(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_key(1'b0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_key(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_key(1'b1, 32'hFFFF_FFFF, 32'd1, 32'h0001_8000, 32'd0);

		// Zero source rotation forces identity; a root scale of 256.0 saturates
		cfg = '{64'd0, 64'd0, 64'd0, {ONE_Q16, 32'd0}, 64'h7FFF_FFFF_8000_0000,
			64'h8000_0000_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF, 64'd16777216};
		load_binds(cfg);
		send_key(1'b0, 32'd5, 32'd6, 32'd7, ONE_Q16);
		send_key(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		send_key(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_key(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);

		// Extreme rotations, wide root scale word, zero root scale after
		cfg = '{64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF};
		load_binds(cfg);
		send_key(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0);
		send_key(1'b0, 32'd1, 32'd0, 32'd0, 32'd0);
		send_key(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'd0);
		random_keys(150);
		cfg[REG_ROOT_SCALE] = 64'd0;
		load_binds(cfg);
		random_keys(50);

		// Random bind settings with random key streams
		for (int ph = 0; ph < 7; ph++) begin
			cfg[REG_SRC_ROT_XY] = {rand_rot(), rand_rot()};
			cfg[REG_SRC_ROT_ZW] = {rand_rot(), rand_rot()};
			cfg[REG_DST_ROT_XY] = {rand_rot(), rand_rot()};
			cfg[REG_DST_ROT_ZW] = {rand_rot(), rand_rot()};
			cfg[REG_SRC_POS_XY] = {rand_comp(), rand_comp()};
			cfg[REG_DST_POS_XY] = {rand_comp(), rand_comp()};
			cfg[REG_POS_Z_PAIR] = {rand_comp(), rand_comp()};
			cfg[REG_ROOT_SCALE] = {$urandom, $urandom >> $urandom_range(0, 31)};
			if (ph == 6) idle_on = 1'b0;
			load_binds(cfg);
			random_keys(200);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d words: %0d rotation keys (%0d identity), %0d translation keys",
			sb.checked, sb.rot_keys, sb.ident_keys, sb.pos_keys);
		$display("Bind settings covered reset, extremes, zero rotation and random values");
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
sv/kpr_pkg.sv
sv/kpr_bscale.sv
sv/kpr_sqrt.sv
sv/keyframe_pose_retarget.sv
verif/tb.sv
